// ----- rtl/core/tdf_pkg.sv -----
package tdf_pkg;

    localparam int FRAC_BITS = 16;
    localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;

    // register indexes on the configuration port
    localparam logic [1:0] REG_SPEED  = 2'd0;
    localparam logic [1:0] REG_FILTER = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE,
        S_M_HDT,
        S_C_H,
        S_M_RH,
        S_M_HW,
        S_M_DD,
        S_M_HD,
        S_M_RL,
        S_M_RU,
        S_C_RAD,
        S_SQRT,
        S_DIV1,
        S_SAT,
        S_DIV2,
        S_M_RS,
        S_M_DTW,
        S_M_DTF,
        S_C_TR,
        S_PUSH
    } t_state;

    // start strobes from the sequencer to the iterative units
    typedef struct packed {
        logic sqrt_start;
        logic div_start;
    } t_iter_ctl;

    // step or width saturation: cap at 2^31-1, lift zero to one lsb
    function automatic logic [30:0] sat_step(input logic [63:0] v);
        logic [30:0] res;
        if (v > {33'd0, MAX31}) begin
            res = MAX31;
        end else if (v == 64'd0) begin
            res = 31'd1;
        end else begin
            res = v[30:0];
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sh00_7FFF_FFFF) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -40'sh00_8000_0000) begin
            res = -32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// ----- rtl/core/tdf_mul.sv -----
module tdf_mul import tdf_pkg::*; (
    input  logic               i_clk,
    input  logic signed [32:0] i_a,
    input  logic signed [32:0] i_b,
    output logic signed [65:0] o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/tdf_div.sv -----
module tdf_div import tdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [30:0] i_den,
    output logic [31:0] o_quo,
    output logic        o_done
);

    // restoring division, one quotient bit a cycle; caller keeps num < den * 2^32
    logic [30:0] r_rem;
    logic [31:0] r_low;
    logic [30:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [31:0] n_trial;
    logic [31:0] n_diff;
    logic        n_ge;

    always_comb begin
        n_trial = {r_rem, r_low[31]};
        n_diff  = n_trial - {1'b0, r_den};
        n_ge    = (n_trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[62:32];
            r_low <= i_num[31:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[30:0] : n_trial[30:0];
            r_low <= {r_low[30:0], n_ge};
        end
    end

    assign o_quo  = r_low;
    assign o_done = r_done;

endmodule

// ----- rtl/core/tdf_sqrt.sv -----
module tdf_sqrt import tdf_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_rad,
    output logic [31:0] o_root,
    output logic        o_done
);

    // digit-by-digit floor square root, one result bit a cycle
    logic [63:0] r_n;
    logic [63:0] r_res;
    logic [63:0] r_bit;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [63:0] n_sum;
    logic        n_ge;

    always_comb begin
        n_sum = r_res + r_bit;
        n_ge  = (r_n >= n_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_rad;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (n_ge) begin
                r_n   <= r_n - n_sum;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[31:0];
    assign o_done = r_done;

endmodule

// ----- rtl/core/tracking_differentiator_fhan_unit.sv -----
// sequence: an accepted setpoint runs through the shared multiplier and one
// pass of the square root or the division; a second division runs if needed
// flow: one word at a time on the shared multiplier and the bit-serial
// square root and divider; the next word is taken once back in idle
// reset: tracked value and rate clear to zero, output valid clears, config registers take their reset values
module tracking_differentiator_fhan_unit import tdf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_setpoint,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_tracked_out,
    output logic signed [31:0] o_rate_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam logic signed [17:0] ONE = 18'sd1 <<< FRAC_BITS;

    t_state r_state;
    t_state n_state;

    logic [30:0] r_speed;
    logic [30:0] r_filter;
    logic [16:0] r_period;

    logic signed [31:0] r_tv;
    logic signed [31:0] r_tr;
    logic               r_out_valid;
    logic signed [31:0] r_out_tv;
    logic signed [31:0] r_out_tr;

    logic signed [32:0] r_x;
    logic [30:0]        r_h;
    logic [30:0]        r_d;
    logic signed [47:0] r_y;
    logic [47:0]        r_ay;
    logic [61:0]        r_dd;
    logic [45:0]        r_d0;
    logic [54:0]        r_plo;
    logic signed [35:0] r_a;
    logic signed [17:0] r_s;
    logic signed [31:0] r_fv;

    logic signed [32:0] n_ma;
    logic signed [32:0] n_mb;
    logic signed [65:0] n_prod;
    logic signed [65:0] n_prod_sh;
    t_iter_ctl          n_ctl;
    logic [63:0]        n_div_num;
    logic [30:0]        n_div_den;
    logic [31:0]        n_quo;
    logic               n_div_done;
    logic [31:0]        n_root;
    logic               n_sqrt_done;

    logic               n_cfg_wr;
    logic               n_in_acc;
    logic               n_out_free;
    logic signed [47:0] n_y;
    logic [78:0]        n_full;
    logic [64:0]        n_sum;
    logic [63:0]        n_rad;
    logic [35:0]        n_mag_a;
    logic signed [33:0] n_diff;
    logic signed [33:0] n_half;
    logic signed [35:0] n_a_sq;
    logic signed [35:0] n_a_dv;
    logic signed [17:0] n_s_dv;
    logic               n_big_y;

    assign n_cfg_wr   = psel & penable & pwrite;
    assign n_in_acc   = i_valid & ~o_stall;
    assign n_out_free = ~r_out_valid | ~i_stall;

    // ---------------- configuration port ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed  <= 31'd6553600;
            r_filter <= 31'd65536;
            r_period <= 17'd262;
        end else if (n_cfg_wr) begin
            unique case (paddr[3:2])
                REG_SPEED:  r_speed  <= pwdata[30:0];
                REG_FILTER: r_filter <= pwdata[30:0];
                REG_PERIOD: r_period <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_SPEED:  prdata = {1'b0, r_speed};
            REG_FILTER: prdata = {1'b0, r_filter};
            REG_PERIOD: prdata = {15'd0, r_period};
            default:    prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- shared units ----------------
    tdf_mul u_mul (
        .i_clk (i_clk),
        .i_a   (n_ma),
        .i_b   (n_mb),
        .o_p   (n_prod)
    );

    tdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_ctl.div_start),
        .i_num   (n_div_num),
        .i_den   (n_div_den),
        .o_quo   (n_quo),
        .o_done  (n_div_done)
    );

    tdf_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_ctl.sqrt_start),
        .i_rad   (n_rad),
        .o_root  (n_root),
        .o_done  (n_sqrt_done)
    );

    // ---------------- datapath helpers ----------------
    always_comb begin
        n_prod_sh = n_prod >>> FRAC_BITS;
        n_y       = $signed({{15{r_x[32]}}, r_x}) + n_prod_sh[47:0];
        // 8*r*|y| from two partial products, then + d*d, saturating at 2^64-1
        n_full    = {24'd0, r_plo} + {n_prod[54:0], 24'd0};
        if (n_full[78:61] != '0) begin
            n_sum = {1'b0, 64'hFFFF_FFFF_FFFF_FFFF};
        end else begin
            n_sum = {1'b0, n_full[60:0], 3'b000} + {3'd0, r_dd};
        end
        n_rad     = n_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : n_sum[63:0];
        n_big_y   = (r_ay > {2'd0, r_d0});
        n_mag_a   = r_a[35] ? 36'(-r_a) : 36'(r_a);
        n_diff    = $signed({2'b00, n_root}) - $signed({3'b000, r_d});
        n_half    = n_diff >>> 1;
        n_a_sq    = r_y[47] ? (36'(r_tr) - 36'(n_half)) : (36'(r_tr) + 36'(n_half));
        n_a_dv    = r_y[47] ? (36'(r_tr) - $signed({4'd0, n_quo}))
                            : (36'(r_tr) + $signed({4'd0, n_quo}));
        n_s_dv    = r_a[35] ? -$signed(n_quo[17:0]) : $signed(n_quo[17:0]);
    end

    // ---------------- sequencer ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (n_in_acc) n_state = S_M_HDT;
            S_M_HDT: n_state = S_C_H;
            S_C_H:   n_state = S_M_RH;
            S_M_RH:  n_state = S_M_HW;
            S_M_HW:  n_state = S_M_DD;
            S_M_DD:  n_state = S_M_HD;
            S_M_HD:  n_state = S_M_RL;
            S_M_RL:  n_state = S_M_RU;
            S_M_RU:  n_state = S_C_RAD;
            S_C_RAD: n_state = n_big_y ? S_SQRT : S_DIV1;
            S_SQRT:  if (n_sqrt_done) n_state = S_SAT;
            S_DIV1:  if (n_div_done) n_state = S_SAT;
            S_SAT:   n_state = (n_mag_a > {5'd0, r_d}) ? S_M_RS : S_DIV2;
            S_DIV2:  if (n_div_done) n_state = S_M_RS;
            S_M_RS:  n_state = S_M_DTW;
            S_M_DTW: n_state = S_M_DTF;
            S_M_DTF: n_state = S_C_TR;
            S_C_TR:  n_state = S_PUSH;
            S_PUSH:  if (n_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ma      = '0;
        n_mb      = '0;
        n_ctl     = '0;
        n_div_num = 64'(r_ay) << FRAC_BITS;
        n_div_den = r_h;
        unique case (r_state)
            S_M_HDT: begin
                n_ma = $signed({2'b00, r_filter});
                n_mb = $signed({16'd0, r_period});
            end
            S_M_RH: begin
                n_ma = $signed({2'b00, r_speed});
                n_mb = $signed({2'b00, r_h});
            end
            S_M_HW: begin
                n_ma = $signed({2'b00, r_h});
                n_mb = 33'(r_tr);
            end
            S_M_DD: begin
                n_ma = $signed({2'b00, r_d});
                n_mb = $signed({2'b00, r_d});
            end
            S_M_HD: begin
                n_ma = $signed({2'b00, r_h});
                n_mb = $signed({2'b00, r_d});
            end
            S_M_RL: begin
                n_ma = $signed({2'b00, r_speed});
                n_mb = $signed({9'd0, r_ay[23:0]});
            end
            S_M_RU: begin
                n_ma = $signed({2'b00, r_speed});
                n_mb = $signed({9'd0, r_ay[47:24]});
            end
            S_C_RAD: begin
                n_ctl.sqrt_start = n_big_y;
                n_ctl.div_start  = ~n_big_y;
            end
            S_SAT: begin
                n_ctl.div_start = ~(n_mag_a > {5'd0, r_d});
                n_div_num       = 64'(n_mag_a) << FRAC_BITS;
                n_div_den       = r_d;
            end
            S_M_RS: begin
                n_ma = $signed({2'b00, r_speed});
                n_mb = 33'(-r_s);
            end
            S_M_DTW: begin
                n_ma = $signed({16'd0, r_period});
                n_mb = 33'(r_tr);
            end
            S_M_DTF: begin
                n_ma = $signed({16'd0, r_period});
                n_mb = 33'(r_fv);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tv        <= '0;
            r_tr        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_M_DTF: r_tv <= clamp32(n_prod_sh[39:0] + 40'(r_tv));
                S_C_TR:  r_tr <= clamp32(n_prod_sh[39:0] + 40'(r_tr));
                S_PUSH:  if (n_out_free) r_out_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // working registers of one word
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE:  r_x  <= 33'(r_tv) - 33'(i_setpoint);
            S_C_H:   r_h  <= sat_step(n_prod_sh[63:0]);
            S_M_HW:  r_d  <= sat_step(n_prod_sh[63:0]);
            S_M_DD: begin
                r_y  <= n_y;
                r_ay <= n_y[47] ? 48'(-n_y) : 48'(n_y);
            end
            S_M_HD:  r_dd  <= n_prod[61:0];
            S_M_RL:  r_d0  <= n_prod_sh[45:0];
            S_M_RU:  r_plo <= n_prod[54:0];
            S_SQRT:  if (n_sqrt_done) r_a <= n_a_sq;
            S_DIV1:  if (n_div_done) r_a <= n_a_dv;
            S_SAT: begin
                if (n_mag_a > {5'd0, r_d}) begin
                    r_s <= r_a[35] ? -ONE : ONE;
                end
            end
            S_DIV2:  if (n_div_done) r_s <= n_s_dv;
            S_M_DTW: r_fv <= clamp32(n_prod_sh[39:0]);
            S_PUSH: begin
                if (n_out_free) begin
                    r_out_tv <= r_tv;
                    r_out_tr <= r_tr;
                end
            end
            default: ;
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_tracked_out = r_out_tv;
    assign o_rate_out    = r_out_tr;

endmodule
